// ===== hw/rtl/ipv4_header_validator_core_assert.svh =====
// Assertion macros shared by the checkers of the IPv4 header validator.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef IPV4_HEADER_VALIDATOR_CORE_ASSERT_SVH
`define IPV4_HEADER_VALIDATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IHV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ipv4hv_pkg.sv =====
// Shared types and constants of the IPv4 header validator.
// Used by the parser, the result buffer, the top level and the checker.
package ipv4hv_pkg;

  localparam int CodeW = 4;
  localparam int HlenW = 6;

  localparam logic [CodeW-1:0] VERDICT_OK       = 4'd0;
  localparam logic [CodeW-1:0] VERDICT_VERSION  = 4'd1;
  localparam logic [CodeW-1:0] VERDICT_HLEN_BIG = 4'd2;
  localparam logic [CodeW-1:0] VERDICT_HLEN_MIN = 4'd3;
  localparam logic [CodeW-1:0] VERDICT_TTL      = 4'd4;
  localparam logic [CodeW-1:0] VERDICT_LENGTH   = 4'd5;
  localparam logic [CodeW-1:0] VERDICT_DST      = 4'd6;
  localparam logic [CodeW-1:0] VERDICT_SRC      = 4'd7;
  localparam logic [CodeW-1:0] VERDICT_CHECKSUM = 4'd8;
  localparam logic [CodeW-1:0] VERDICT_PROTOCOL = 4'd9;

  localparam logic [HlenW-1:0] MIN_HLEN = 6'd20;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic CFG_IDX_CHK_EN = 1'b0;

  typedef struct packed {
    logic [CodeW-1:0] verdict_code;
    logic             accepted;
    logic [7:0]       protocol;
    logic [HlenW-1:0] header_length;
  } result_t;

endpackage

// ===== hw/rtl/ipv4hv_parse.sv =====
// Header parser of the IPv4 header validator: per-packet state and verdict logic.
// Depends on ipv4hv_pkg for verdict codes and the result type.
module ipv4hv_parse
  import ipv4hv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_fire,
  input  logic [7:0]  header_byte,
  input  logic        first_of_packet,
  input  logic [15:0] frame_length,
  input  logic        chk_en,
  output logic        res_fire,
  output result_t     res
);

  localparam logic [5:0] OFS_TLEN_HI  = 6'd2;
  localparam logic [5:0] OFS_TLEN_LO  = 6'd3;
  localparam logic [5:0] OFS_TTL      = 6'd8;
  localparam logic [5:0] OFS_PROTO    = 6'd9;
  localparam logic [5:0] OFS_CSUM_HI  = 6'd10;
  localparam logic [5:0] OFS_CSUM_LO  = 6'd11;
  localparam logic [5:0] OFS_SRC_FST  = 6'd12;
  localparam logic [5:0] OFS_SRC_LST  = 6'd15;
  localparam logic [5:0] OFS_DST_FST  = 6'd16;
  localparam logic [5:0] OFS_DST_LST  = 6'd19;

  logic        active_r, active_nxt;
  logic [5:0]  byte_idx_r, byte_idx_nxt;
  logic [5:0]  hdr_bytes_r, hdr_bytes_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic        csum_nz_r, csum_nz_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic [5:0]  hlen;
  logic [16:0] word_sum;
  logic        last_byte;
  logic [CodeW-1:0] code;

  always_comb begin
    active_nxt    = active_r;
    byte_idx_nxt  = byte_idx_r;
    hdr_bytes_nxt = hdr_bytes_r;
    frame_len_nxt = frame_len_r;
    sum_nxt       = sum_r;
    pend_nxt      = pend_r;
    tlen_nxt      = tlen_r;
    ttl_nxt       = ttl_r;
    proto_nxt     = proto_r;
    csum_nz_nxt   = csum_nz_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    hlen          = {header_byte[3:0], 2'b00};
    word_sum      = {1'b0, sum_r} + {1'b0, pend_r, header_byte};
    last_byte     = ({1'b0, byte_idx_r} + 7'd1) >= {1'b0, hdr_bytes_r};
    code          = VERDICT_OK;
    res_fire      = 1'b0;
    res           = '0;

    if (item_fire && first_of_packet) begin
      frame_len_nxt = frame_length;
      hdr_bytes_nxt = hlen;
      active_nxt    = 1'b0;
      byte_idx_nxt  = '0;
      tlen_nxt      = '0;
      ttl_nxt       = '0;
      proto_nxt     = '0;
      csum_nz_nxt   = 1'b0;
      src_nxt       = '0;
      dst_nxt       = '0;
      sum_nxt       = '0;
      pend_nxt      = header_byte;
      res.header_length = hlen;
      res.protocol      = '0;
      if (header_byte[7:4] != 4'd4) begin
        res_fire = 1'b1;
        code     = VERDICT_VERSION;
      end else if ({10'd0, hlen} >= frame_length) begin
        res_fire = 1'b1;
        code     = VERDICT_HLEN_BIG;
      end else if (hlen < MIN_HLEN) begin
        res_fire = 1'b1;
        code     = VERDICT_HLEN_MIN;
      end else begin
        active_nxt   = 1'b1;
        byte_idx_nxt = 6'd1;
      end
    end else if (item_fire && active_r) begin
      if (!byte_idx_r[0]) begin
        pend_nxt = header_byte;
      end else begin
        sum_nxt = word_sum[15:0] + {15'd0, word_sum[16]};
      end

      case (byte_idx_r) inside
        OFS_TLEN_HI: tlen_nxt = {header_byte, 8'd0};
        OFS_TLEN_LO: tlen_nxt = {tlen_r[15:8], header_byte};
        OFS_TTL: ttl_nxt = header_byte;
        OFS_PROTO: proto_nxt = header_byte;
        OFS_CSUM_HI: csum_nz_nxt = header_byte != 8'd0;
        OFS_CSUM_LO: csum_nz_nxt = csum_nz_r || (header_byte != 8'd0);
        [OFS_SRC_FST:OFS_SRC_LST]: src_nxt = {src_r[23:0], header_byte};
        [OFS_DST_FST:OFS_DST_LST]: dst_nxt = {dst_r[23:0], header_byte};
        default: ;
      endcase

      if (last_byte) begin
        active_nxt   = 1'b0;
        byte_idx_nxt = '0;
        res_fire     = 1'b1;
        if (ttl_nxt == 8'd0) begin
          code = VERDICT_TTL;
        end else if (tlen_nxt != frame_len_r) begin
          code = VERDICT_LENGTH;
        end else if (dst_nxt == 32'd0 || dst_nxt == 32'hFFFF_FFFF) begin
          code = VERDICT_DST;
        end else if (src_nxt == 32'd0 || src_nxt == 32'hFFFF_FFFF) begin
          code = VERDICT_SRC;
        end else if (chk_en && csum_nz_nxt && sum_nxt != 16'hFFFF) begin
          code = VERDICT_CHECKSUM;
        end else if (proto_nxt != PROTO_UDP && proto_nxt != PROTO_TCP &&
                     proto_nxt != PROTO_ICMP) begin
          code = VERDICT_PROTOCOL;
        end
        res.protocol      = proto_nxt;
        res.header_length = hdr_bytes_r;
      end else begin
        byte_idx_nxt = byte_idx_r + 6'd1;
      end
    end

    res.verdict_code = code;
    res.accepted     = code == VERDICT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      byte_idx_r <= '0;
    end else begin
      active_r   <= active_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_bytes_r <= hdr_bytes_nxt;
    frame_len_r <= frame_len_nxt;
    sum_r       <= sum_nxt;
    pend_r      <= pend_nxt;
    tlen_r      <= tlen_nxt;
    ttl_r       <= ttl_nxt;
    proto_r     <= proto_nxt;
    csum_nz_r   <= csum_nz_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
  end

endmodule

// ===== hw/rtl/ipv4hv_out_buf.sv =====
// Result register with a skid stage for the IPv4 header validator.
// Depends on ipv4hv_pkg for the result type.
module ipv4hv_out_buf
  import ipv4hv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= push_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/ipv4_header_validator_core.sv =====
// Top level of the IPv4 header validator: configuration port and channel glue.
// Depends on ipv4hv_pkg, ipv4hv_parse and ipv4hv_out_buf.
//
// Header bytes enter the in_ channel in network order, one per cycle while not stalled.
// The item with in_first_of_packet high is byte 0 and carries the frame length.
// One verdict item per packet leaves on the out_ channel: at once after byte 0
// when the version or header length is bad, else after the last header byte.
// A start marker in the middle of a header drops that packet without a verdict.
// Throughput is one byte per cycle while in_stall is low. The parser state
// is updated in a single pass at the accepting edge, and the verdict that
// the accepted byte completes lands in a result register.
// If the receiver stalls, one further verdict is held in a skid register and
// in_stall rises only while that skid register is occupied.
// Reset clears the parser's active state and the valid flags of both result
// registers and disables the checksum test. The checksum enable lies at byte
// address 0 of the register port; the port is always ready.
module ipv4_header_validator_core
  import ipv4hv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_header_byte,
  input  logic        in_first_of_packet,
  input  logic [15:0] in_frame_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_verdict_code,
  output logic        out_accepted,
  output logic [7:0]  out_protocol,
  output logic [5:0]  out_header_length
);

  logic    chk_en_r;
  logic    cfg_wr;
  logic    item_fire;
  logic    res_fire;
  result_t res;
  result_t out_res;
  logic    buf_full;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_CHK_EN) ? {31'd0, chk_en_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_en_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_CHK_EN) begin
      chk_en_r <= cfg_pwdata[0];
    end
  end

  assign in_stall  = buf_full;
  assign item_fire = in_valid && !in_stall;

  ipv4hv_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_fire       (item_fire),
    .header_byte     (in_header_byte),
    .first_of_packet (in_first_of_packet),
    .frame_length    (in_frame_length),
    .chk_en          (chk_en_r),
    .res_fire        (res_fire),
    .res             (res)
  );

  ipv4hv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_fire),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_verdict_code  = out_res.verdict_code;
  assign out_accepted      = out_res.accepted;
  assign out_protocol      = out_res.protocol;
  assign out_header_length = out_res.header_length;

endmodule

// ===== hw/rtl/ipv4hv_checker.sv =====
// Port-level checker of the IPv4 header validator, bound to the top level.
// Depends on ipv4hv_pkg and the assertion macros header.
`include "ipv4_header_validator_core_assert.svh"

module ipv4hv_checker
  import ipv4hv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_verdict_code,
  input logic       out_accepted,
  input logic [7:0] out_protocol,
  input logic [5:0] out_header_length
);

  logic [18:0] out_payload;
  logic        flag_ok;
  logic        early_rej;
  logic        proto_zero;
  logic        ok_out;
  logic        hlen_ok;
  logic        stalled;

  assign out_payload = {out_verdict_code, out_accepted, out_protocol, out_header_length};
  assign flag_ok     = out_accepted == (out_verdict_code == VERDICT_OK);
  assign early_rej   = out_valid && (out_verdict_code == VERDICT_VERSION ||
                                     out_verdict_code == VERDICT_HLEN_BIG ||
                                     out_verdict_code == VERDICT_HLEN_MIN);
  assign proto_zero  = out_protocol == 8'd0;
  assign ok_out      = out_valid && out_accepted;
  assign hlen_ok     = out_header_length >= MIN_HLEN && out_header_length[1:0] == 2'b00;
  assign stalled     = out_valid && out_stall;

  `IHV_ASSERT_NOW(a_accept_flag, out_valid, flag_ok, "accepted flag disagrees with verdict")
  `IHV_ASSERT_NOW(a_early_proto, early_rej, proto_zero, "protocol on early reject")
  `IHV_ASSERT_NOW(a_ok_hlen, ok_out, hlen_ok, "accepted with bad header length")
  `IHV_ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(out_payload), "stall not held")

endmodule

bind ipv4_header_validator_core ipv4hv_checker u_checker (.*);
